// ===== src/ebpf_pkg.sv =====
package ebpf_pkg;

    localparam int unsigned XLEN          = 64;
    localparam int unsigned PC_W          = 12;
    localparam int unsigned LEN_W         = 13;
    localparam int unsigned PROGRAM_SLOTS = 4096;
    localparam int unsigned REG_NUM       = 10;
    localparam int unsigned REG_IDX_W     = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_ENTRY_PC  = 2'd0;
    localparam logic [1:0] CFG_PROG_LEN  = 2'd1;
    localparam logic [1:0] CFG_CTX_PTR   = 2'd2;
    localparam logic [1:0] CFG_FRAME_PTR = 2'd3;

    // fault codes
    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_DIV0  = 2'd1;
    localparam logic [1:0] FLT_ILLOP = 2'd2;
    localparam logic [1:0] FLT_RANGE = 2'd3;

    // alu operation codes (opcode bits 7:4)
    localparam logic [3:0] OP_ADD  = 4'h0;
    localparam logic [3:0] OP_SUB  = 4'h1;
    localparam logic [3:0] OP_MUL  = 4'h2;
    localparam logic [3:0] OP_DIV  = 4'h3;
    localparam logic [3:0] OP_OR   = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LSH  = 4'h6;
    localparam logic [3:0] OP_RSH  = 4'h7;
    localparam logic [3:0] OP_NEG  = 4'h8;
    localparam logic [3:0] OP_MOD  = 4'h9;
    localparam logic [3:0] OP_XOR  = 4'hA;
    localparam logic [3:0] OP_MOV  = 4'hB;
    localparam logic [3:0] OP_ARSH = 4'hC;
    localparam logic [3:0] OP_END  = 4'hD;

    // jump codes
    localparam logic [3:0] JOP_JA   = 4'h0;
    localparam logic [3:0] JOP_JEQ  = 4'h1;
    localparam logic [3:0] JOP_JGT  = 4'h2;
    localparam logic [3:0] JOP_JGE  = 4'h3;
    localparam logic [3:0] JOP_JSET = 4'h4;
    localparam logic [3:0] JOP_JNE  = 4'h5;
    localparam logic [3:0] JOP_JSGT = 4'h6;
    localparam logic [3:0] JOP_JSGE = 4'h7;

    // instruction classes
    localparam logic [2:0] CLS_LD    = 3'd0;
    localparam logic [2:0] CLS_ALU   = 3'd4;
    localparam logic [2:0] CLS_JMP   = 3'd5;
    localparam logic [2:0] CLS_ALU64 = 3'd7;

    localparam logic [7:0] OPC_EXIT = 8'h95;
    localparam logic [7:0] OPC_JA   = 8'h05;
    localparam logic [7:0] OPC_LDDW = 8'h18;

    // byte-order widths
    localparam logic [31:0] BO_16 = 32'd16;
    localparam logic [31:0] BO_32 = 32'd32;
    localparam logic [31:0] BO_64 = 32'd64;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [3:0]  dst_reg;
        logic [3:0]  src_reg;
        logic [15:0] offset;
        logic [31:0] immediate;
    } t_insn;

    // byte reverse over the low n bytes
    function automatic logic [63:0] swap16(input logic [63:0] v);
        swap16 = {48'd0, v[7:0], v[15:8]};
    endfunction

    function automatic logic [63:0] swap32(input logic [63:0] v);
        swap32 = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [63:0] swap64(input logic [63:0] v);
        swap64 = {v[7:0], v[15:8], v[23:16], v[31:24],
                  v[39:32], v[47:40], v[55:48], v[63:56]};
    endfunction

endpackage

// ===== src/ebpf_instruction_executor.sv =====
// channel   | direction | handshake                  | payload
// s_axis    | in        | s_axis_tvalid/tready       | instruction slot in tdata
// m_axis    | out       | m_axis_tvalid/tready       | next pc, return value in tdata
// cfg       | in        | i_cfg_valid/o_cfg_ready    | register index and write data
//
// most instructions pass through accept, execute and result.
// multiply and divide/modulo hold the shared shift-add/subtract unit,
// one bit per cycle, then write back.
// reset is synchronous active low and clears the registers; a restart loads r1 with the context pointer.
// input is not taken while a result waits or a cfg write is offered;
// output stalls hold the result.
module ebpf_instruction_executor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // cfg write
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // instruction slots
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[7:0], dst_reg[11:8], src_reg[15:12], offset[31:16], immediate[63:32]
    input  logic [63:0]  s_axis_tdata,
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[11:0], done_res[12], return_value[76:13], fault[78:77], zeros above
    output logic [79:0]  m_axis_tdata
);
    import ebpf_pkg::*;

    localparam int unsigned LIM_W = $clog2(PROGRAM_SLOTS) + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_state;
    logic [63:0] r_regs [REG_NUM];
    logic [PC_W-1:0] r_pc;
    logic        r_pend;
    logic [31:0] r_lo;
    logic [3:0]  r_tgt;
    logic        r_halt;
    logic [PC_W-1:0]  r_entry;
    logic [LEN_W-1:0] r_len;
    logic [63:0] r_ctx;
    logic [63:0] r_fp;
    t_insn       r_in;
    logic [63:0] r_a, r_b;
    logic [63:0] r_acc, r_rem, r_q;
    logic [6:0]  r_cnt;
    logic [79:0] r_out;

    // accept / handshake
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_out;

    // decode fields of the held instruction
    logic [2:0] cls;
    logic [3:0] code;
    logic       use_src, wide;
    logic [LIM_W-1:0] limit, pcx;
    logic [LIM_W+16:0] tgt_fall, tgt_jmp;
    assign cls     = r_in.opcode[2:0];
    assign code    = r_in.opcode[7:4];
    assign use_src = r_in.opcode[3];
    assign wide    = (cls == CLS_ALU64);
    assign limit   = (LIM_W'(r_len) > LIM_W'(PROGRAM_SLOTS)) ? LIM_W'(PROGRAM_SLOTS)
                                                             : LIM_W'(r_len);
    assign pcx     = LIM_W'(r_pc);
    assign tgt_fall = (LIM_W+17)'(pcx) + (LIM_W+17)'(1);
    assign tgt_jmp  = tgt_fall + {{(LIM_W+1){r_in.offset[15]}}, r_in.offset};

    function automatic logic [63:0] rd(input logic [3:0] i, input logic [63:0] fp,
                                       input logic [63:0] rf [REG_NUM]);
        rd = (i >= 4'(REG_NUM)) ? fp : rf[i];
    endfunction

    // shared alu result, masked to operand width
    logic [63:0] a_m, b_m, alu_r;
    logic [5:0]  sh;
    assign a_m = wide ? r_a : {32'd0, r_a[31:0]};
    assign b_m = wide ? r_b : {32'd0, r_b[31:0]};
    assign sh  = wide ? b_m[5:0] : {1'b0, b_m[4:0]};
    always_comb begin
        case (code)
            OP_ADD:  alu_r = a_m + b_m;
            OP_SUB:  alu_r = a_m - b_m;
            OP_OR:   alu_r = a_m | b_m;
            OP_AND:  alu_r = a_m & b_m;
            OP_LSH:  alu_r = a_m << sh;
            OP_RSH:  alu_r = a_m >> sh;
            OP_NEG:  alu_r = 64'd0 - a_m;
            OP_XOR:  alu_r = a_m ^ b_m;
            OP_MOV:  alu_r = b_m;
            OP_ARSH: alu_r = wide ? 64'($signed(a_m) >>> sh)
                                  : {32'd0, 32'($signed(a_m[31:0]) >>> sh[4:0])};
            default: alu_r = a_m;
        endcase
        if (!wide) alu_r = {32'd0, alu_r[31:0]};
    end

    // byte-order conversion
    logic [63:0] end_r;
    always_comb begin
        end_r = r_a;
        if (r_in.immediate == BO_16)      end_r = use_src ? swap16(r_a) : {48'd0, r_a[15:0]};
        else if (r_in.immediate == BO_32) end_r = use_src ? swap32(r_a) : {32'd0, r_a[31:0]};
        else if (r_in.immediate == BO_64 && use_src) end_r = swap64(r_a);
    end

    // branch compare
    logic take;
    always_comb begin
        unique case (code)
            JOP_JEQ:  take = r_a == r_b;
            JOP_JGT:  take = r_a > r_b;
            JOP_JGE:  take = r_a >= r_b;
            JOP_JSET: take = (r_a & r_b) != 64'd0;
            JOP_JNE:  take = r_a != r_b;
            JOP_JSGT: take = $signed(r_a) > $signed(r_b);
            JOP_JSGE: take = $signed(r_a) >= $signed(r_b);
            default:  take = 1'b0;
        endcase
    end

    logic illegal_alu, illegal_jmp;
    assign illegal_alu = (code > OP_END) || (code == OP_NEG && use_src) ||
                         (code == OP_END && wide) || (r_in.dst_reg >= 4'(REG_NUM)) ||
                         (use_src && r_in.src_reg > 4'(REG_NUM));
    assign illegal_jmp = (code == JOP_JA) || (code > JOP_JSGE) ||
                         (r_in.dst_reg > 4'(REG_NUM)) ||
                         (use_src && r_in.src_reg > 4'(REG_NUM));

    logic fall_bad, jmp_bad;
    assign fall_bad = tgt_fall >= (LIM_W+17)'(limit);
    assign jmp_bad  = tgt_jmp[LIM_W+16] || (tgt_jmp >= (LIM_W+17)'(limit));

    // alu instruction that goes ahead, and whether it needs the iterative unit
    logic div0, alu_go;
    assign div0   = (code == OP_DIV || code == OP_MOD) && b_m == 64'd0;
    assign alu_go = !r_halt && (pcx < limit) && !r_pend &&
                    (cls == CLS_ALU || cls == CLS_ALU64) && !illegal_alu && !div0 && !fall_bad;

    // shared iterative unit: one bit per cycle of multiply or divide
    logic [6:0]  nbits;
    logic [64:0] rem_sh, rem_sub;
    assign nbits   = wide ? 7'd64 : 7'd32;
    assign rem_sh  = {r_rem, r_q[63]};
    assign rem_sub = rem_sh - {1'b0, b_m};

    function automatic logic [79:0] pack(input logic [PC_W-1:0] p, input logic d,
                                         input logic [63:0] v, input logic [1:0] f);
        pack = {1'b0, f, v, d, p};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_entry <= '0; r_len <= '0; r_ctx <= '0; r_fp <= '0;
            for (int i = 0; i < REG_NUM; i++) r_regs[i] <= '0;
            r_pc <= '0; r_pend <= 1'b0; r_lo <= '0; r_tgt <= '0; r_halt <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        unique case (i_cfg_index)
                            CFG_PROG_LEN:  r_len <= i_cfg_data[LEN_W-1:0];
                            CFG_FRAME_PTR: r_fp  <= i_cfg_data;
                            default: begin
                                // restart on entry pc or context pointer
                                for (int i = 0; i < REG_NUM; i++)
                                    r_regs[i] <= (i == 1) ?
                                        ((i_cfg_index == CFG_ENTRY_PC) ? r_ctx : i_cfg_data) :
                                        '0;
                                if (i_cfg_index == CFG_ENTRY_PC) begin
                                    r_entry <= i_cfg_data[PC_W-1:0];
                                    r_pc    <= i_cfg_data[PC_W-1:0];
                                end else begin
                                    r_ctx   <= i_cfg_data;
                                    r_pc    <= r_entry;
                                end
                                r_pend <= 1'b0; r_lo <= '0; r_tgt <= '0; r_halt <= 1'b0;
                            end
                        endcase
                    end else if (s_axis_tvalid) begin
                        r_in.opcode    <= s_axis_tdata[7:0];
                        r_in.dst_reg   <= s_axis_tdata[11:8];
                        r_in.src_reg   <= s_axis_tdata[15:12];
                        r_in.offset    <= s_axis_tdata[31:16];
                        r_in.immediate <= s_axis_tdata[63:32];
                        // operand read
                        r_a <= rd(s_axis_tdata[11:8], r_fp, r_regs);
                        r_b <= s_axis_tdata[3] ? rd(s_axis_tdata[15:12], r_fp, r_regs)
                                               : {{32{s_axis_tdata[63]}}, s_axis_tdata[63:32]};
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_state <= !alu_go ? ST_OUT :
                               (code == OP_MUL) ? ST_MUL :
                               (code == OP_DIV || code == OP_MOD) ? ST_DIV : ST_OUT;
                    if (r_halt)
                        r_out <= pack(r_pc, 1'b1, r_regs[0], FLT_NONE);
                    else if (pcx >= limit)
                        r_out <= pack(r_pc, 1'b0, '0, FLT_RANGE);
                    else if (r_pend) begin
                        if (fall_bad) r_out <= pack(r_pc, 1'b0, '0, FLT_RANGE);
                        else begin
                            r_regs[r_tgt] <= {r_in.immediate, r_lo};
                            r_pend <= 1'b0;
                            r_pc   <= tgt_fall[PC_W-1:0];
                            r_out  <= pack(tgt_fall[PC_W-1:0], 1'b0, '0, FLT_NONE);
                        end
                    end else if (cls == CLS_ALU || cls == CLS_ALU64) begin
                        if (illegal_alu) r_out <= pack(r_pc, 1'b0, '0, FLT_ILLOP);
                        else if (div0)
                            r_out <= pack(r_pc, 1'b0, '0, FLT_DIV0);
                        else if (fall_bad) r_out <= pack(r_pc, 1'b0, '0, FLT_RANGE);
                        else if (code == OP_MUL) begin
                            r_acc <= '0; r_q <= a_m; r_cnt <= '0;
                        end else if (code == OP_DIV || code == OP_MOD) begin
                            r_rem <= '0; r_q <= wide ? a_m : {a_m[31:0], 32'd0};
                            r_cnt <= '0;
                        end else begin
                            r_regs[r_in.dst_reg] <= (code == OP_END) ? end_r : alu_r;
                            r_pc  <= tgt_fall[PC_W-1:0];
                            r_out <= pack(tgt_fall[PC_W-1:0], 1'b0, '0, FLT_NONE);
                        end
                    end else if (cls == CLS_JMP) begin
                        if (r_in.opcode == OPC_EXIT) begin
                            r_halt <= 1'b1;
                            r_out  <= pack(r_pc, 1'b1, r_regs[0], FLT_NONE);
                        end else if (r_in.opcode != OPC_JA && illegal_jmp)
                            r_out <= pack(r_pc, 1'b0, '0, FLT_ILLOP);
                        else if ((r_in.opcode == OPC_JA || take) ? jmp_bad : fall_bad)
                            r_out <= pack(r_pc, 1'b0, '0, FLT_RANGE);
                        else begin
                            r_pc  <= (r_in.opcode == OPC_JA || take) ? tgt_jmp[PC_W-1:0]
                                                                    : tgt_fall[PC_W-1:0];
                            r_out <= pack((r_in.opcode == OPC_JA || take) ?
                                          tgt_jmp[PC_W-1:0] : tgt_fall[PC_W-1:0],
                                          1'b0, '0, FLT_NONE);
                        end
                    end else if (r_in.opcode == OPC_LDDW) begin
                        if (r_in.dst_reg >= 4'(REG_NUM)) r_out <= pack(r_pc, 1'b0, '0, FLT_ILLOP);
                        else if (fall_bad) r_out <= pack(r_pc, 1'b0, '0, FLT_RANGE);
                        else begin
                            r_pend <= 1'b1; r_lo <= r_in.immediate; r_tgt <= r_in.dst_reg;
                            r_pc  <= tgt_fall[PC_W-1:0];
                            r_out <= pack(tgt_fall[PC_W-1:0], 1'b0, '0, FLT_NONE);
                        end
                    end else
                        r_out <= pack(r_pc, 1'b0, '0, FLT_ILLOP);
                end
                ST_MUL: begin
                    // shift-add, one multiplier bit per cycle
                    if (r_cnt == nbits) begin
                        r_regs[r_in.dst_reg] <= wide ? r_acc : {32'd0, r_acc[31:0]};
                        r_pc    <= tgt_fall[PC_W-1:0];
                        r_out   <= pack(tgt_fall[PC_W-1:0], 1'b0, '0, FLT_NONE);
                        r_state <= ST_OUT;
                    end else begin
                        r_acc <= r_q[0] ? (r_acc + (b_m << r_cnt[5:0])) : r_acc;
                        r_q   <= r_q >> 1;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (r_cnt == nbits) begin
                        r_regs[r_in.dst_reg] <= (code == OP_DIV) ?
                            (wide ? r_q : {32'd0, r_q[31:0]}) :
                            (wide ? r_rem : {32'd0, r_rem[31:0]});
                        r_pc    <= tgt_fall[PC_W-1:0];
                        r_out   <= pack(tgt_fall[PC_W-1:0], 1'b0, '0, FLT_NONE);
                        r_state <= ST_OUT;
                    end else begin
                        if (!rem_sub[64]) begin
                            r_rem <= rem_sub[63:0];
                            r_q   <= {r_q[62:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[63:0];
                            r_q   <= {r_q[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // a result is offered only after execution
    a_out_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_EXEC || $past(r_state) == ST_MUL ||
                                  $past(r_state) == ST_DIV))
        else $error("result without execution");
    // no input taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");
    // once halted, results report done with no fault
    a_halt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_halt && $stable(r_halt) && $past(r_halt))
            |-> (m_axis_tdata[12] && m_axis_tdata[78:77] == FLT_NONE))
        else $error("halted result not done");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ebpf_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // opcode[7:0], dst_reg[11:8], src_reg[15:12], offset[31:16], immediate[63:32]
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // next_pc[11:0], done_res[12], return_value[76:13], fault[78:77], zeros above
    logic [79:0]  m_axis_tdata;

    ebpf_instruction_executor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    typedef struct packed {
        logic [11:0] next_pc;
        logic        done_res;
        logic [63:0] return_value;
        logic [1:0]  fault;
    } t_outcome;

    // shadow architectural state
    logic [11:0] sh_entry_pc;
    logic [12:0] sh_prog_len;
    logic [63:0] sh_ctx_ptr;
    logic [63:0] sh_frame_ptr;
    logic [63:0] sh_regs [0:9];
    logic [11:0] sh_pc;
    logic        sh_wide_pending;
    logic [31:0] sh_wide_low;
    logic [3:0]  sh_wide_dst;
    logic        sh_halted;

    t_insn    insn_q [$];
    t_outcome outcome_q [$];
    t_insn    cur_insn;
    int       err_count;
    int       outcome_seen;
    int       fault_seen [0:3];
    int       stall_left;
    int       gap_left;
    bit       hold_insns;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] byte_rev(input logic [63:0] v, input int nbytes);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < nbytes; i++) r = (r << 8) | ((v >> (8 * i)) & 64'hFF);
        return r;
    endfunction

    function automatic t_outcome halt_outcome(input logic [1:0] f);
        t_outcome o;
        o.next_pc = sh_pc;
        o.done_res = 1'b0;
        o.return_value = '0;
        o.fault = f;
        return o;
    endfunction

    task automatic restart_core();
        for (int i = 0; i < 10; i++) sh_regs[i] = '0;
        sh_regs[1] = sh_ctx_ptr;
        sh_pc = sh_entry_pc;
        sh_wide_pending = 1'b0;
        sh_wide_low = '0;
        sh_wide_dst = '0;
        sh_halted = 1'b0;
    endtask

    task automatic apply_cfg_shadow(input logic [1:0] idx, input logic [63:0] val);
        case (idx)
            CFG_ENTRY_PC: begin
                sh_entry_pc = val[11:0];
                restart_core();
            end
            CFG_PROG_LEN: sh_prog_len = val[12:0];
            CFG_CTX_PTR: begin
                sh_ctx_ptr = val;
                restart_core();
            end
            default: sh_frame_ptr = val;
        endcase
    endtask

    function automatic logic [63:0] reg_read(input logic [3:0] i);
        return (i >= 10) ? sh_frame_ptr : sh_regs[i];
    endfunction

    // execute one slot against the shadow state
    function automatic t_outcome execute_slot(input t_insn s);
        t_outcome o;
        logic [2:0]  cls;
        logic [3:0]  code;
        logic        use_src, wide, take;
        logic [63:0] imm, a, b, r;
        logic [5:0]  sh;
        longint      target, lim;
        cls = s.opcode[2:0];
        code = s.opcode[7:4];
        use_src = s.opcode[3];
        imm = {{32{s.immediate[31]}}, s.immediate};
        lim = (sh_prog_len < PROGRAM_SLOTS) ? sh_prog_len : PROGRAM_SLOTS;
        target = longint'(sh_pc) + 1;
        o = halt_outcome(FLT_NONE);
        if (sh_halted) begin
            o.done_res = 1'b1;
            o.return_value = sh_regs[0];
            return o;
        end
        if (longint'(sh_pc) >= lim) return halt_outcome(FLT_RANGE);
        if (sh_wide_pending) begin
            if (target >= lim) return halt_outcome(FLT_RANGE);
            sh_regs[sh_wide_dst % 10] = {s.immediate, sh_wide_low};
            sh_wide_pending = 1'b0;
            sh_pc = target[11:0];
            return halt_outcome(FLT_NONE);
        end
        if (cls == CLS_ALU || cls == CLS_ALU64) begin
            wide = (cls == CLS_ALU64);
            if (code > OP_END || (code == OP_NEG && use_src) || (code == OP_END && wide) ||
                s.dst_reg >= 10 || (use_src && s.src_reg >= 11))
                return halt_outcome(FLT_ILLOP);
            a = sh_regs[s.dst_reg];
            b = use_src ? reg_read(s.src_reg) : imm;
            if (!wide) begin
                a = a & 64'hFFFF_FFFF;
                b = b & 64'hFFFF_FFFF;
            end
            if ((code == OP_DIV || code == OP_MOD) && b == 0) return halt_outcome(FLT_DIV0);
            sh = wide ? b[5:0] : {1'b0, b[4:0]};
            case (code)
                OP_ADD:  r = a + b;
                OP_SUB:  r = a - b;
                OP_MUL:  r = a * b;
                OP_DIV:  r = a / b;
                OP_OR:   r = a | b;
                OP_AND:  r = a & b;
                OP_LSH:  r = a << sh;
                OP_RSH:  r = a >> sh;
                OP_NEG:  r = 64'd0 - a;
                OP_MOD:  r = a % b;
                OP_XOR:  r = a ^ b;
                OP_MOV:  r = b;
                OP_ARSH: r = wide ? 64'($signed(a) >>> sh)
                                  : {32'd0, 32'($signed(a[31:0]) >>> sh)};
                default: begin
                    r = sh_regs[s.dst_reg];
                    if (s.immediate == BO_16) r = use_src ? byte_rev(r, 2) : (r & 64'hFFFF);
                    else if (s.immediate == BO_32)
                        r = use_src ? byte_rev(r, 4) : (r & 64'hFFFF_FFFF);
                    else if (s.immediate == BO_64 && use_src) r = byte_rev(r, 8);
                end
            endcase
            if (!wide && code != OP_END) r = r & 64'hFFFF_FFFF;
            if (target >= lim) return halt_outcome(FLT_RANGE);
            sh_regs[s.dst_reg] = r;
        end else if (cls == CLS_JMP) begin
            if (s.opcode == OPC_EXIT) begin
                sh_halted = 1'b1;
                o.done_res = 1'b1;
                o.return_value = sh_regs[0];
                return o;
            end
            if (s.opcode == OPC_JA) begin
                target += longint'($signed(s.offset));
            end else begin
                if (code == JOP_JA || code > JOP_JSGE || s.dst_reg >= 11 ||
                    (use_src && s.src_reg >= 11))
                    return halt_outcome(FLT_ILLOP);
                a = reg_read(s.dst_reg);
                b = use_src ? reg_read(s.src_reg) : imm;
                case (code)
                    JOP_JEQ:  take = (a == b);
                    JOP_JGT:  take = (a > b);
                    JOP_JGE:  take = (a >= b);
                    JOP_JSET: take = ((a & b) != 0);
                    JOP_JNE:  take = (a != b);
                    JOP_JSGT: take = ($signed(a) > $signed(b));
                    default:  take = ($signed(a) >= $signed(b));
                endcase
                if (take) target += longint'($signed(s.offset));
            end
            if (target < 0 || target >= lim) return halt_outcome(FLT_RANGE);
        end else if (s.opcode == OPC_LDDW) begin
            if (s.dst_reg >= 10) return halt_outcome(FLT_ILLOP);
            if (target >= lim) return halt_outcome(FLT_RANGE);
            sh_wide_pending = 1'b1;
            sh_wide_low = s.immediate;
            sh_wide_dst = s.dst_reg;
        end else begin
            return halt_outcome(FLT_ILLOP);
        end
        sh_pc = target[11:0];
        return halt_outcome(FLT_NONE);
    endfunction

    // instruction driver
    always @(posedge i_clk) begin
        t_insn nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                outcome_q.push_back(execute_slot(cur_insn));
            end
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (insn_q.size() != 0 && !hold_insns) begin
                nxt = insn_q.pop_front();
                cur_insn <= nxt;
                s_axis_tdata <= {nxt.immediate, nxt.offset, nxt.src_reg, nxt.dst_reg,
                                 nxt.opcode};
                s_axis_tvalid <= 1'b1;
                gap_left <= $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and ready stalls
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.next_pc = m_axis_tdata[11:0];
                got.done_res = m_axis_tdata[12];
                got.return_value = m_axis_tdata[76:13];
                got.fault = m_axis_tdata[78:77];
                outcome_seen++;
                if (outcome_q.size() == 0) begin
                    $error("unexpected result transaction %h", got);
                    err_count++;
                end else begin
                    want = outcome_q.pop_front();
                    fault_seen[want.fault]++;
                    if (got.next_pc !== want.next_pc) begin
                        $error("next_pc exp %h got %h", want.next_pc, got.next_pc);
                        err_count++;
                    end
                    if (got.done_res !== want.done_res) begin
                        $error("done_res exp %h got %h", want.done_res, got.done_res);
                        err_count++;
                    end
                    if (got.return_value !== want.return_value) begin
                        $error("return_value exp %h got %h", want.return_value,
                               got.return_value);
                        err_count++;
                    end
                    if (got.fault !== want.fault) begin
                        $error("fault exp %h got %h", want.fault, got.fault);
                        err_count++;
                    end
                end
                stall_left <= $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
                m_axis_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_insn mk(input logic [7:0] op, input logic [3:0] d, input logic [3:0] s,
                                 input logic [15:0] off, input logic [31:0] imm);
        t_insn t;
        t.opcode = op;
        t.dst_reg = d;
        t.src_reg = s;
        t.offset = off;
        t.immediate = imm;
        return t;
    endfunction

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 70));
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed instructions, some noise
    function automatic t_insn rand_insn();
        logic [7:0] op;
        logic [3:0] d, s;
        logic [15:0] off;
        d = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
        s = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
        off = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 8)) - 4);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:
                op = {4'($urandom_range(0, 13)), 1'($urandom), ($urandom_range(0, 1) ? CLS_ALU64
                                                                                  : CLS_ALU)};
            8, 9, 10, 11: op = {4'($urandom_range(1, 7)), 1'($urandom), CLS_JMP};
            12: op = OPC_JA;
            13, 14: op = OPC_LDDW;
            15: op = OPC_EXIT;
            default: op = 8'($urandom);
        endcase
        return mk(op, d, s, off, rand_imm());
    endfunction

    task automatic wait_drain();
        while (insn_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_cfg_shadow(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic setup_program(input logic [11:0] entry, input logic [12:0] len,
                                 input logic [63:0] ctx, input logic [63:0] fp);
        write_cfg(CFG_PROG_LEN, {51'd0, len});
        write_cfg(CFG_FRAME_PTR, fp);
        write_cfg(CFG_CTX_PTR, ctx);
        write_cfg(CFG_ENTRY_PC, {52'd0, entry});
        @(posedge i_clk);
    endtask

    initial begin
        err_count = 0;
        outcome_seen = 0;
        hold_insns = 1'b0;
        for (int i = 0; i < 4; i++) fault_seen[i] = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        sh_entry_pc = '0;
        sh_prog_len = '0;
        sh_ctx_ptr = '0;
        sh_frame_ptr = '0;
        restart_core();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero length after reset: every slot out of range
        insn_q.push_back(mk(8'h07, 4'd0, 4'd0, 16'd0, 32'd1));
        wait_drain();

        setup_program(12'd0, 13'd4096, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
        insn_q.push_back(mk(8'hB7, 4'd0, 4'd0, 16'd0, 32'hFFFF_FFFF));    // mov64 sign-extend
        insn_q.push_back(mk(8'h04, 4'd2, 4'd0, 16'd0, 32'h7FFF_FFFF));    // add32
        insn_q.push_back(mk(8'h3F, 4'd0, 4'd2, 16'd0, 32'd0));            // div64 by r2
        insn_q.push_back(mk(8'h34, 4'd0, 4'd0, 16'd0, 32'd0));            // div32 zero
        insn_q.push_back(mk(8'h94, 4'd1, 4'd0, 16'd0, 32'd7));            // mod32
        insn_q.push_back(mk(8'h6F, 4'd0, 4'd10, 16'd0, 32'd0));           // lsh by r10
        insn_q.push_back(mk(8'hC7, 4'd1, 4'd0, 16'd0, 32'd127));          // arsh64 masked
        insn_q.push_back(mk(8'hC4, 4'd0, 4'd0, 16'd0, 32'd33));           // arsh32 masked
        insn_q.push_back(mk(8'h8C, 4'd0, 4'd0, 16'd0, 32'd0));            // neg with src bit
        insn_q.push_back(mk(8'h87, 4'd3, 4'd0, 16'd0, 32'd0));            // neg64
        insn_q.push_back(mk(8'hDC, 4'd1, 4'd0, 16'd0, BO_16));            // be16
        insn_q.push_back(mk(8'hDC, 4'd1, 4'd0, 16'd0, BO_64));            // be64
        insn_q.push_back(mk(8'hD4, 4'd1, 4'd0, 16'd0, BO_32));            // le32
        insn_q.push_back(mk(8'hD4, 4'd1, 4'd0, 16'd0, 32'd8));            // odd width
        insn_q.push_back(mk(8'hDF, 4'd1, 4'd0, 16'd0, BO_16));            // 64-bit class swap
        insn_q.push_back(mk(8'hB7, 4'd10, 4'd0, 16'd0, 32'd1));           // write r10
        insn_q.push_back(mk(8'h1D, 4'd15, 4'd0, 16'd1, 32'd0));           // bad dst index
        insn_q.push_back(mk(8'h6D, 4'd10, 4'd1, 16'h7FFF, 32'd0));        // jsgt far
        insn_q.push_back(mk(8'h05, 4'd0, 4'd0, 16'h8000, 32'd0));         // ja negative
        insn_q.push_back(mk(OPC_LDDW, 4'd4, 4'd0, 16'd0, 32'hDEAD_BEEF));
        insn_q.push_back(mk(8'hFF, 4'hF, 4'hF, 16'hFFFF, 32'h1234_5678)); // high half
        insn_q.push_back(mk(8'hFF, 4'd0, 4'd0, 16'd0, 32'd0));            // unknown opcode
        insn_q.push_back(mk(OPC_EXIT, 4'd0, 4'd0, 16'd0, 32'd0));
        insn_q.push_back(mk(8'h07, 4'd0, 4'd0, 16'd0, 32'd1));            // after exit
        wait_drain();

        // wide load on the last slot, then an add whose next pc lies past the end
        setup_program(12'd4095, 13'd4096, 64'd5, 64'd0);
        insn_q.push_back(mk(OPC_LDDW, 4'd0, 4'd0, 16'd0, 32'd1));
        insn_q.push_back(mk(8'h07, 4'd0, 4'd0, 16'd0, 32'd1));
        wait_drain();

        // random programs under varied settings
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: setup_program(12'd0, 13'd8191, 64'($urandom) << 32 | $urandom, 64'd0);
                1: setup_program(12'd3, 13'd16, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
                default: setup_program(12'($urandom_range(0, 40)), 13'($urandom_range(30, 4096)),
                                       {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            for (int n = 0; n < 50; n++) begin
                insn_q.push_back(rand_insn());
                if (n == 25 && phase == 2) begin
                    // hold off until the block has answered everything
                    while (insn_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
                    hold_insns = 1'b1;
                    while (outcome_q.size() != 0) @(posedge i_clk);
                    hold_insns = 1'b0;
                end
            end
            wait_drain();
        end

        $display("tb: %0d results checked, faults none/div0/illop/range = %0d/%0d/%0d/%0d",
                 outcome_seen, fault_seen[0], fault_seen[1], fault_seen[2], fault_seen[3]);
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: errors");
        $finish;
    end
endmodule
